// ----- src/qmgs_pkg.sv -----
// Shared types and constants for the modified Gram-Schmidt QR core.
`default_nettype none
package qmgs_pkg;

	localparam int MAX_ROWS   = 4;
	localparam int MAX_COLS   = 4;
	localparam int POS_W      = 2;
	localparam int VAL_W      = 32;
	localparam int SIZE_W     = 3;
	localparam int FLOOR_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ACC_W      = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT  = 2'd0,
		REG_COL_COUNT  = 2'd1,
		REG_FULL_Q     = 2'd2,
		REG_NORM_FLOOR = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_COPY,
		OP_SQ_CLR,
		OP_SQ_RD,
		OP_SQ_MUL,
		OP_SQ_ACC,
		OP_SQRT_GO,
		OP_NORM_SET,
		OP_Q_RD,
		OP_DIV_GO,
		OP_Q_WR,
		OP_DOT_CLR,
		OP_DOT_RD,
		OP_DOT_MUL,
		OP_DOT_ACC,
		OP_DOT_FIN,
		OP_UPD_MUL,
		OP_UPD_WR,
		OP_OUT_RD,
		OP_OUT_LD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_is_r;
		logic   out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic dep;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- src/qmgs_if.sv -----
// Valid/ready channel interfaces for matrix elements in and Q/R elements out.
`default_nettype none
interface qmgs_elem_if import qmgs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        elem_row;
	logic [POS_W-1:0]        elem_col;
	logic signed [VAL_W-1:0] elem_value;
	logic                    last_element;

	modport source (output valid, output elem_row, output elem_col, output elem_value,
		output last_element, input ready);
	modport sink (input valid, input elem_row, input elem_col, input elem_value,
		input last_element, output ready);
endinterface

interface qmgs_res_if import qmgs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    which_matrix;
	logic [POS_W-1:0]        out_row;
	logic [POS_W-1:0]        out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    last_result;

	modport source (output valid, output which_matrix, output out_row, output out_col,
		output out_value, output last_result, input ready);
	modport sink (input valid, input which_matrix, input out_row, input out_col,
		input out_value, input last_result, output ready);
endinterface
`default_nettype wire

// ----- src/qmgs_sqrt.sv -----
// Iterative 64-bit integer square root, two radicand bits per cycle.
`default_nettype none
module qmgs_sqrt import qmgs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] radicand,
	output logic             done,
	output logic [31:0]      root
);

	logic [ACC_W-1:0] v_q, res_q, bit_q, trial;
	logic             busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule
`default_nettype wire

// ----- src/qmgs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module qmgs_div #(
	parameter int NUM_W = 49
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [31:0]      den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [31:0]      rem_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [32:0]      part;
	logic             qbit;

	assign part = {rem_q, num_q[NUM_W-1]};
	assign qbit = part >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(part - {1'b0, den_q}) : part[31:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule
`default_nettype wire

// ----- src/qmgs_dp.sv -----
// Datapath: element stores, shared multiplier, accumulators, sqrt/div units, output register.
`default_nettype none
module qmgs_dp import qmgs_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int NW        = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [POS_W-1:0]        load_row,
	input  logic [POS_W-1:0]        load_col,
	input  logic signed [VAL_W-1:0] load_value,
	input  dp_cmd_t                 cmd,
	input  logic [NW-1:0]           row,
	input  logic [NW-1:0]           col_a,
	input  logic [NW-1:0]           col_b,
	input  logic [NW-1:0]           k,
	input  logic [FLOOR_W-1:0]      norm_floor,
	output dp_stat_t                stat,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic                    which_matrix,
	output logic [POS_W-1:0]        out_row,
	output logic [POS_W-1:0]        out_col,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    last_result
);

	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int WDEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW     = $clog2(WDEPTH);
	localparam int RDEPTH = MAX_COLS * MAX_COLS;
	localparam int RAW    = $clog2(RDEPTH);
	localparam int NUM_W  = 33 + FRAC_BITS;

	function automatic logic [AW-1:0] w_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
		return AW'(32'(r[RW-1:0]) * MAX_COLS + 32'(c[CW-1:0]));
	endfunction

	function automatic logic [RAW-1:0] r_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
		return RAW'(32'(r[CW-1:0]) * MAX_COLS + 32'(c[CW-1:0]));
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W:0] v);
		if (v[ACC_W:VAL_W-1] == '0 || v[ACC_W:VAL_W-1] == '1)
			return v[VAL_W-1:0];
		return v[ACC_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	function automatic logic signed [ACC_W-1:0] rshift(input logic signed [ACC_W-1:0] v);
		logic [ACC_W:0] m;
		logic [ACC_W:0] r;
		m = v[ACC_W-1] ? ((ACC_W+1)'(0) - {1'b1, v}) : {1'b0, v};
		r = (m + ((ACC_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[ACC_W-1] ? ACC_W'((ACC_W+1)'(0) - r) : r[ACC_W-1:0];
	endfunction

	logic signed [VAL_W-1:0] wmem [WDEPTH];
	logic signed [VAL_W-1:0] cmem [WDEPTH];
	logic signed [VAL_W-1:0] qmem [WDEPTH];
	logic signed [VAL_W-1:0] rmem [RDEPTH];
	logic [MAX_COLS-1:0]     dep_q;

	logic signed [VAL_W-1:0] wrd_q, crd_q, qrd_q, rrd_q, dot_q;
	logic [AW-1:0]           copy_addr_q;
	logic                    copy_pend_q, res_valid_q;
	logic signed [ACC_W-1:0] prod_q, acc_q;
	logic [ACC_W-1:0]        sum_q;
	logic                    sign_q;

	logic signed [VAL_W-1:0] mul_a, mul_b, dot_new, q_new, norm_sat, upd_new, out_v;
	logic [ACC_W:0]          sq_sum;
	logic signed [ACC_W:0]   dot_sum;
	logic signed [ACC_W-1:0] acc_new;
	logic [31:0]             norm, crd_mag;
	logic                    sqrt_done, div_done, dep, big;
	logic [NUM_W-1:0]        div_num, quo;

	qmgs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT_GO),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (norm)
	);

	assign crd_mag = crd_q[VAL_W-1] ? 32'(33'd0 - {1'b1, crd_q}) : crd_q;
	assign div_num = (NUM_W'(crd_mag) << FRAC_BITS) + NUM_W'(norm >> 1);

	qmgs_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_GO),
		.num    (div_num),
		.den    (norm),
		.done   (div_done),
		.quo    (quo)
	);

	assign dep      = (norm == '0) || (norm < 32'(norm_floor));
	assign norm_sat = norm[31] ? 32'sh7FFF_FFFF : norm;
	assign big      = |quo[NUM_W-1:VAL_W-1];

	always_comb begin
		if (sign_q)
			q_new = big ? 32'sh8000_0000 : 32'(33'd0 - {1'b0, quo[VAL_W-1:0]});
		else
			q_new = big ? 32'sh7FFF_FFFF : quo[VAL_W-1:0];
	end

	always_comb begin
		mul_a = crd_q;
		mul_b = crd_q;
		case (cmd.op)
			OP_DOT_MUL: begin
				mul_a = qrd_q;
				mul_b = crd_q;
			end
			OP_UPD_MUL: begin
				mul_a = dot_q;
				mul_b = qrd_q;
			end
			default: ;
		endcase
	end

	assign sq_sum  = {1'b0, sum_q} + {1'b0, prod_q};
	assign dot_sum = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
	assign acc_new = (dot_sum[ACC_W] != dot_sum[ACC_W-1]) ?
		(dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		dot_sum[ACC_W-1:0];
	assign dot_new = sat32((ACC_W+1)'(rshift(acc_q)));
	assign upd_new = sat32((ACC_W+1)'(crd_q) - (ACC_W+1)'(rshift(prod_q)));

	always_comb begin
		if (!cmd.out_is_r) begin
			if (col_b < k)
				out_v = dep_q[col_b[CW-1:0]] ? '0 : qrd_q;
			else
				out_v = (row == col_b) ? (32'sd1 <<< FRAC_BITS) : '0;
		end else begin
			out_v = (dep_q[row[CW-1:0]] || (col_b < row)) ? '0 : rrd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load && (32'(load_row) < MAX_ROWS) && (32'(load_col) < MAX_COLS))
			wmem[AW'(32'(load_row) * MAX_COLS + 32'(load_col))] <= load_value;
		if (cmd.op == OP_COPY)
			wrd_q <= wmem[w_addr(row, col_b)];
	end

	always_ff @(posedge clk) begin
		if (copy_pend_q)
			cmem[copy_addr_q] <= wrd_q;
		else if (cmd.op == OP_UPD_WR)
			cmem[w_addr(row, col_b)] <= upd_new;
		if (cmd.op == OP_SQ_RD || cmd.op == OP_Q_RD)
			crd_q <= cmem[w_addr(row, col_a)];
		else if (cmd.op == OP_DOT_RD)
			crd_q <= cmem[w_addr(row, col_b)];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_Q_WR)
			qmem[w_addr(row, col_a)] <= q_new;
		if (cmd.op == OP_DOT_RD)
			qrd_q <= qmem[w_addr(row, col_a)];
		else if (cmd.op == OP_OUT_RD)
			qrd_q <= qmem[w_addr(row, col_b)];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_NORM_SET)
			rmem[r_addr(col_a, col_a)] <= norm_sat;
		else if (cmd.op == OP_DOT_FIN)
			rmem[r_addr(col_a, col_b)] <= dot_new;
		if (cmd.op == OP_OUT_RD)
			rrd_q <= rmem[r_addr(row, col_b)];
	end

	always_ff @(posedge clk) begin
		copy_addr_q <= w_addr(row, col_b);
		if (cmd.op == OP_SQ_MUL || cmd.op == OP_DOT_MUL || cmd.op == OP_UPD_MUL)
			prod_q <= mul_a * mul_b;
		if (cmd.op == OP_SQ_CLR)
			sum_q <= '0;
		else if (cmd.op == OP_SQ_ACC)
			sum_q <= sq_sum[ACC_W] ? '1 : sq_sum[ACC_W-1:0];
		if (cmd.op == OP_DOT_CLR)
			acc_q <= '0;
		else if (cmd.op == OP_DOT_ACC)
			acc_q <= acc_new;
		if (cmd.op == OP_DOT_FIN)
			dot_q <= dot_new;
		if (cmd.op == OP_DIV_GO)
			sign_q <= crd_q[VAL_W-1];
		if (cmd.op == OP_NORM_SET)
			dep_q[col_a[CW-1:0]] <= dep;
		if (cmd.op == OP_OUT_LD) begin
			which_matrix <= cmd.out_is_r;
			out_row      <= row[POS_W-1:0];
			out_col      <= col_b[POS_W-1:0];
			out_value    <= out_v;
			last_result  <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			copy_pend_q <= (cmd.op == OP_COPY);
			if (cmd.op == OP_OUT_LD)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign res_valid      = res_valid_q;
	assign stat.sqrt_done = sqrt_done;
	assign stat.div_done  = div_done;
	assign stat.dep       = dep;
	assign stat.out_free  = !res_valid_q || res_ready;

endmodule
`default_nettype wire

// ----- src/qmgs_ctrl.sv -----
// Controller: sequences load, column sweeps, norm, normalize, project-out and emission.
`default_nettype none
module qmgs_ctrl import qmgs_pkg::*; #(
	parameter int NW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_accept,
	input  logic          in_last,
	output logic          in_ready,
	input  logic [NW-1:0] m,
	input  logic [NW-1:0] n,
	input  logic [NW-1:0] k,
	input  logic [NW-1:0] qcols,
	input  dp_stat_t      stat,
	output dp_cmd_t       cmd,
	output logic [NW-1:0] row,
	output logic [NW-1:0] col_a,
	output logic [NW-1:0] col_b
);

	typedef enum logic [23:0] {
		S_IDLE      = 24'h000001,
		S_COPY      = 24'h000002,
		S_SQ_CLR    = 24'h000004,
		S_SQ_RD     = 24'h000008,
		S_SQ_MUL    = 24'h000010,
		S_SQ_ACC    = 24'h000020,
		S_SQRT_GO   = 24'h000040,
		S_SQRT_WAIT = 24'h000080,
		S_NORM_SET  = 24'h000100,
		S_Q_RD      = 24'h000200,
		S_DIV_GO    = 24'h000400,
		S_DIV_WAIT  = 24'h000800,
		S_Q_WR      = 24'h001000,
		S_DOT_CLR   = 24'h002000,
		S_DOT_RD    = 24'h004000,
		S_DOT_MUL   = 24'h008000,
		S_DOT_ACC   = 24'h010000,
		S_DOT_FIN   = 24'h020000,
		S_UPD_RD    = 24'h040000,
		S_UPD_MUL   = 24'h080000,
		S_UPD_WR    = 24'h100000,
		S_NEXT_COL  = 24'h200000,
		S_OUT_RD    = 24'h400000,
		S_OUT_LD    = 24'h800000
	} state_t;

	state_t        state_q, state_d;
	logic [NW-1:0] i_q, i_d, j_q, j_d, c_q, c_d;
	logic          rph_q, rph_d;
	logic          i_end, c_end_n, j_next_ok, c_next_ok;

	assign i_end     = (i_q == NW'(m - 1'b1));
	assign c_end_n   = (c_q == NW'(n - 1'b1));
	assign j_next_ok = (NW'(j_q + 1'b1) < n);
	assign c_next_ok = (NW'(c_q + 1'b1) < n);

	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		j_d          = j_q;
		c_d          = c_q;
		rph_d        = rph_q;
		cmd.op       = OP_NONE;
		cmd.out_is_r = rph_q;
		cmd.out_last = rph_q && (i_q == NW'(k - 1'b1)) && c_end_n;
		case (state_q)
			S_IDLE: begin
				if (in_accept && in_last) begin
					i_d     = '0;
					c_d     = '0;
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				cmd.op = OP_COPY;
				if (c_end_n) begin
					c_d = '0;
					if (i_end) begin
						j_d     = '0;
						state_d = S_SQ_CLR;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					c_d = c_q + 1'b1;
				end
			end
			S_SQ_CLR: begin
				cmd.op  = OP_SQ_CLR;
				i_d     = '0;
				state_d = S_SQ_RD;
			end
			S_SQ_RD: begin
				cmd.op  = OP_SQ_RD;
				state_d = S_SQ_MUL;
			end
			S_SQ_MUL: begin
				cmd.op  = OP_SQ_MUL;
				state_d = S_SQ_ACC;
			end
			S_SQ_ACC: begin
				cmd.op = OP_SQ_ACC;
				if (i_end) begin
					state_d = S_SQRT_GO;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_SQ_RD;
				end
			end
			S_SQRT_GO: begin
				cmd.op  = OP_SQRT_GO;
				state_d = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (stat.sqrt_done)
					state_d = S_NORM_SET;
			end
			S_NORM_SET: begin
				cmd.op = OP_NORM_SET;
				i_d    = '0;
				state_d = stat.dep ? S_NEXT_COL : S_Q_RD;
			end
			S_Q_RD: begin
				cmd.op  = OP_Q_RD;
				state_d = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.op  = OP_DIV_GO;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done)
					state_d = S_Q_WR;
			end
			S_Q_WR: begin
				cmd.op = OP_Q_WR;
				if (i_end) begin
					c_d     = NW'(j_q + 1'b1);
					state_d = j_next_ok ? S_DOT_CLR : S_NEXT_COL;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_Q_RD;
				end
			end
			S_DOT_CLR: begin
				cmd.op  = OP_DOT_CLR;
				i_d     = '0;
				state_d = S_DOT_RD;
			end
			S_DOT_RD: begin
				cmd.op  = OP_DOT_RD;
				state_d = S_DOT_MUL;
			end
			S_DOT_MUL: begin
				cmd.op  = OP_DOT_MUL;
				state_d = S_DOT_ACC;
			end
			S_DOT_ACC: begin
				cmd.op = OP_DOT_ACC;
				if (i_end) begin
					state_d = S_DOT_FIN;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_DOT_RD;
				end
			end
			S_DOT_FIN: begin
				cmd.op  = OP_DOT_FIN;
				i_d     = '0;
				state_d = S_UPD_RD;
			end
			S_UPD_RD: begin
				cmd.op  = OP_DOT_RD;
				state_d = S_UPD_MUL;
			end
			S_UPD_MUL: begin
				cmd.op  = OP_UPD_MUL;
				state_d = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.op = OP_UPD_WR;
				if (i_end) begin
					c_d     = c_q + 1'b1;
					state_d = c_next_ok ? S_DOT_CLR : S_NEXT_COL;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_UPD_RD;
				end
			end
			S_NEXT_COL: begin
				if (j_q == NW'(k - 1'b1)) begin
					i_d     = '0;
					c_d     = '0;
					rph_d   = 1'b0;
					state_d = S_OUT_RD;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = S_SQ_CLR;
				end
			end
			S_OUT_RD: begin
				cmd.op  = OP_OUT_RD;
				state_d = S_OUT_LD;
			end
			S_OUT_LD: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT_LD;
					state_d = S_OUT_RD;
					if (!rph_q) begin
						if (c_q == NW'(qcols - 1'b1)) begin
							c_d = '0;
							if (i_end) begin
								i_d   = '0;
								rph_d = 1'b1;
							end else begin
								i_d = i_q + 1'b1;
							end
						end else begin
							c_d = c_q + 1'b1;
						end
					end else begin
						if (c_end_n) begin
							c_d = '0;
							if (i_q == NW'(k - 1'b1))
								state_d = S_IDLE;
							else
								i_d = i_q + 1'b1;
						end else begin
							c_d = c_q + 1'b1;
						end
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			c_q     <= '0;
			rph_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			c_q     <= c_d;
			rph_q   <= rph_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign row      = i_q;
	assign col_a    = j_q;
	assign col_b    = c_q;

endmodule
`default_nettype wire

// ----- src/qr_modified_gram_schmidt_core.sv -----
// Top level: configuration registers, size clamping, controller and datapath.
// Loading: one element per cycle while idle. The last element starts the decomposition.
// After the last element (m rows, n cols, k = min(m,n)) the matrix is copied; then each of the
// first k columns gets its norm (sqrt, 32 steps), is normalized (divider, one bit a cycle)
// and is projected out of every later column; then the Q/R elements are emitted.
// Reset: clears control state; registers return to 4 rows, 4 cols, reduced Q, floor 1.
`default_nettype none
module qr_modified_gram_schmidt_core import qmgs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qmgs_elem_if.sink             elem,
	qmgs_res_if.source            res,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int NW   = $clog2(MAXD + 1);

	logic [SIZE_W-1:0]  row_count_q, col_count_q;
	logic               full_q_q;
	logic [FLOOR_W-1:0] norm_floor_q;
	logic [NW-1:0]      m, n, k, qcols;
	logic               in_accept;
	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic [NW-1:0]      row, col_a, col_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= SIZE_W'(4);
			col_count_q  <= SIZE_W'(4);
			full_q_q     <= 1'b0;
			norm_floor_q <= FLOOR_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT:  row_count_q  <= cfg_data[SIZE_W-1:0];
				REG_COL_COUNT:  col_count_q  <= cfg_data[SIZE_W-1:0];
				REG_FULL_Q:     full_q_q     <= cfg_data[0];
				REG_NORM_FLOOR: norm_floor_q <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign m = (row_count_q == '0) ? NW'(1) :
		((32'(row_count_q) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(row_count_q));
	assign n = (col_count_q == '0) ? NW'(1) :
		((32'(col_count_q) > MAX_COLS) ? NW'(MAX_COLS) : NW'(col_count_q));
	assign k     = (m < n) ? m : n;
	assign qcols = full_q_q ? m : k;

	assign in_accept = elem.valid && elem.ready;

	qmgs_ctrl #(.NW(NW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_last   (elem.last_element),
		.in_ready  (elem.ready),
		.m         (m),
		.n         (n),
		.k         (k),
		.qcols     (qcols),
		.stat      (stat),
		.cmd       (cmd),
		.row       (row),
		.col_a     (col_a),
		.col_b     (col_b)
	);

	qmgs_dp #(
		.FRAC_BITS (FRAC_BITS),
		.NW        (NW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_accept),
		.load_row     (elem.elem_row),
		.load_col     (elem.elem_col),
		.load_value   (elem.elem_value),
		.cmd          (cmd),
		.row          (row),
		.col_a        (col_a),
		.col_b        (col_b),
		.k            (k),
		.norm_floor   (norm_floor_q),
		.stat         (stat),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.which_matrix (res.which_matrix),
		.out_row      (res.out_row),
		.out_col      (res.out_col),
		.out_value    (res.out_value),
		.last_result  (res.last_result)
	);

endmodule
`default_nettype wire

// ----- verif/tb_qr_modified_gram_schmidt_core.sv -----
// Testbench for the modified Gram-Schmidt QR core: random matrices, bit-exact Q/R prediction.
`default_nettype none
module tb_qr_modified_gram_schmidt_core;
	import qmgs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic        which;
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        last;
	} qr_elem_t;

	class mgs_board;
		int          work[16];
		int          qm[16];
		int          rm[16];
		logic [2:0]  rows_reg = 4;
		logic [2:0]  cols_reg = 4;
		logic        full_reg = 0;
		logic [15:0] floor_reg = 1;
		qr_elem_t    expected_q[$];
		int          errors = 0;

		function void set_reg(cfg_reg_t idx, logic [15:0] val);
			case (idx)
				REG_ROW_COUNT:  rows_reg = val[2:0];
				REG_COL_COUNT:  cols_reg = val[2:0];
				REG_FULL_Q:     full_reg = val[0];
				REG_NORM_FLOOR: floor_reg = val;
				default: ;
			endcase
		endfunction

		function int clamp(logic [2:0] v);
			return v == 0 ? 1 : (v > 4 ? 4 : int'(v));
		endfunction

		function int sat32(longint v);
			if (v > 64'sd2147483647) return 32'h7fffffff;
			if (v < -64'sd2147483648) return 32'h80000000;
			return int'(v);
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function longint rshift(longint v);
			longint unsigned m;
			m = (mag(v) + 64'd32768) >> FB;
			return v < 0 ? -longint'(m) : longint'(m);
		endfunction

		function longint add_sat(longint a, longint b);
			logic signed [64:0] t;
			t = {a[63], a} + {b[63], b};
			if (t > 65'sh0_7fffffff_ffffffff) return 64'h7fffffff_ffffffff;
			if (t < -65'sh0_8000000000000000) return 64'h80000000_00000000;
			return t[63:0];
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function void note_elem(logic [1:0] er, logic [1:0] ec, logic [31:0] v, logic last);
			int w[16];
			int m, n, k, qc, cnt, total;
			longint unsigned sum, a, sq, norm, qmag;
			logic [64:0] s65;
			longint num, acc;
			int dot;
			qr_elem_t e;
			work[er*4+ec] = v;
			if (!last) return;
			m = clamp(rows_reg);
			n = clamp(cols_reg);
			k = m < n ? m : n;
			qc = full_reg ? m : k;
			w = work;
			foreach (qm[i]) qm[i] = 0;
			foreach (rm[i]) rm[i] = 0;
			for (int j = 0; j < k; j++) begin
				sum = 0;
				for (int i = 0; i < m; i++) begin
					a = mag(longint'(w[i*4+j]));
					sq = a * a;
					s65 = {1'b0, sum} + {1'b0, sq};
					sum = s65[64] ? '1 : s65[63:0];
				end
				norm = int_sqrt(sum);
				if (norm == 0 || norm < {48'd0, floor_reg}) continue;
				for (int i = 0; i < m; i++) begin
					num = longint'(w[i*4+j]) * 65536;
					qmag = (mag(num) + norm / 2) / norm;
					qm[i*4+j] = sat32(num < 0 ? -longint'(qmag) : longint'(qmag));
				end
				rm[j*4+j] = sat32(longint'(norm));
				for (int c = j + 1; c < n; c++) begin
					acc = 0;
					for (int i = 0; i < m; i++)
						acc = add_sat(acc, longint'(qm[i*4+j]) * longint'(w[i*4+c]));
					dot = sat32(rshift(acc));
					rm[j*4+c] = dot;
					for (int i = 0; i < m; i++)
						w[i*4+c] = sat32(longint'(w[i*4+c])
							- rshift(longint'(dot) * longint'(qm[i*4+j])));
				end
			end
			for (int j = k; j < qc; j++)
				for (int i = 0; i < m; i++)
					qm[i*4+j] = (i == j) ? 65536 : 0;
			total = m * qc + k * n;
			cnt = 0;
			for (int i = 0; i < m; i++)
				for (int c = 0; c < qc; c++) begin
					e = '{1'b0, 2'(i), 2'(c), qm[i*4+c], 1'b0};
					expected_q.push_back(e);
					cnt++;
				end
			for (int i = 0; i < k; i++)
				for (int c = 0; c < n; c++) begin
					e = '{1'b1, 2'(i), 2'(c), rm[i*4+c], cnt == total - 1};
					expected_q.push_back(e);
					cnt++;
				end
		endfunction

		function void check_result(qr_elem_t got);
			qr_elem_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction: matrix %0d row %0d col %0d",
					got.which, got.row, got.col);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.which !== e.which) begin
				$error("which_matrix: expected %0d, got %0d", e.which, got.which); errors++;
			end
			if (got.row !== e.row) begin
				$error("out_row: expected %0d, got %0d", e.row, got.row); errors++;
			end
			if (got.col !== e.col) begin
				$error("out_col: expected %0d, got %0d", e.col, got.col); errors++;
			end
			if (got.value !== e.value) begin
				$error("out_value: expected %h, got %h", e.value, got.value); errors++;
			end
			if (got.last !== e.last) begin
				$error("last_result: expected %0d, got %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int send_pct = 0;
	int recv_pct = 0;
	int stall_cnt = 0;
	mgs_board sb = new;

	qmgs_elem_if elem();
	qmgs_res_if res();

	qr_modified_gram_schmidt_core uut (
		.clk(clk), .arst_n(arst_n), .elem(elem.sink), .res(res.source),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(negedge clk) begin
		res.ready = ($urandom_range(99) >= recv_pct);
	end

	always @(posedge clk) begin
		qr_elem_t got;
		if (arst_n) begin
			if (elem.valid && elem.ready)
				sb.note_elem(elem.elem_row, elem.elem_col, elem.elem_value, elem.last_element);
			if (res.valid && res.ready) begin
				got = '{res.which_matrix, res.out_row, res.out_col, res.out_value,
					res.last_result};
				sb.check_result(got);
			end
			if ((elem.valid && elem.ready) || (res.valid && res.ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("qr_modified_gram_schmidt_core test failed");
				$finish;
			end
		end
	end

	task automatic send_elem(int r, int c, logic [31:0] v, logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_pct) begin
			elem.valid = 0;
			@(negedge clk);
		end
		elem.valid = 1;
		elem.elem_row = 2'(r);
		elem.elem_col = 2'(c);
		elem.elem_value = v;
		elem.last_element = last;
		do @(posedge clk); while (!elem.ready);
		@(negedge clk);
		elem.valid = 0;
	endtask

	task automatic drain(int extra);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_index = idx;
		cfg_data = 16'(val);
		sb.set_reg(idx, 16'(val));
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	function automatic logic [31:0] pick_value(int kind);
		case (kind)
			1: return $urandom;
			4: return 32'($signed($urandom_range(6)) - 3);
			default: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
		endcase
	endfunction

	// kind: 0 small, 1 full range, 2 zero column, 3 dependent column, 4 tiny
	task automatic load_matrix(int kind, bit stale_ok);
		int m, n, zc, cnt;
		int pos[$];
		logic [31:0] v[16];
		m = sb.clamp(sb.rows_reg);
		n = sb.clamp(sb.cols_reg);
		zc = $urandom_range(n - 1);
		for (int i = 0; i < 16; i++) v[i] = pick_value(kind);
		for (int i = 0; i < m; i++) begin
			if (kind == 2) v[i*4+zc] = 0;
			if (kind == 3 && n > 1) v[i*4+n-1] = v[i*4];
		end
		for (int i = 0; i < m; i++)
			for (int c = 0; c < n; c++)
				if (!stale_ok || $urandom_range(5) != 0) pos.push_back(i*4+c);
		if (pos.size() == 0) pos.push_back(0);
		pos.shuffle();
		cnt = pos.size();
		foreach (pos[i])
			send_elem(pos[i] / 4, pos[i] % 4, v[pos[i]], i == cnt - 1);
	endtask

	int phases[10][4] = '{
		'{4, 2, 1, 0}, '{0, 3, 1, 65535}, '{7, 7, 0, 1}, '{3, 1, 1, 100},
		'{1, 4, 0, 0}, '{2, 3, 1, 1}, '{4, 3, 1, 16}, '{4, 4, 1, 1},
		'{3, 3, 0, 65535}, '{4, 1, 1, 2}
	};
	int idle_modes[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{20, 20}};

	initial begin
		logic [31:0] corner[16];
		corner = '{32'h7fffffff, 32'h80000000, 0, 32'h00010000,
			32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h00000001,
			32'h80000000, 0, 32'h7fffffff, 32'hffff0000,
			0, 32'h00000001, 32'hffffffff, 32'h80000000};
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = REG_ROW_COUNT;
		cfg_data = 0;
		elem.valid = 0;
		elem.elem_row = 0;
		elem.elem_col = 0;
		elem.elem_value = 0;
		elem.last_element = 0;
		res.ready = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int i = 0; i < 16; i++) send_elem(i / 4, i % 4, corner[i], i == 15);
		drain(40);
		load_matrix(3, 0);
		load_matrix(2, 0);
		drain(40);

		for (int p = 0; p < 10; p++) begin
			write_reg(REG_ROW_COUNT, phases[p][0]);
			write_reg(REG_COL_COUNT, phases[p][1]);
			write_reg(REG_FULL_Q, phases[p][2]);
			write_reg(REG_NORM_FLOOR, phases[p][3]);
			send_pct = idle_modes[p % 4][0];
			recv_pct = idle_modes[p % 4][1];
			for (int t = 0; t < 1; t++) begin
				if ($urandom_range(3) == 0) load_matrix($urandom_range(4), 1);
				else load_matrix($urandom_range(3) == 0 ? 1 : 0, 1);
			end
			load_matrix(p % 5, 1);
			drain(40);
		end

		drain(100);
		if (sb.errors == 0)
			$display("qr_modified_gram_schmidt_core test passed");
		else
			$display("qr_modified_gram_schmidt_core test failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
src/qmgs_pkg.sv
src/qmgs_if.sv
src/qmgs_sqrt.sv
src/qmgs_div.sv
src/qmgs_dp.sv
src/qmgs_ctrl.sv
src/qr_modified_gram_schmidt_core.sv
verif/tb_qr_modified_gram_schmidt_core.sv
